[rtl/core/mqsb_pkg.sv]
package mqsb_pkg;

   localparam int QID_W    = 2;
   localparam int QID_SPAN = 1 << QID_W;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

[rtl/core/mqsb_ram.sv]
module mqsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mqsb_link_store.sv]
module mqsb_link_store #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic                             alloc_en,
   input  logic [$clog2(NUM_SLOTS)-1:0]     rd_addr,
   output logic [$clog2(NUM_SLOTS+1)-1:0]   rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(NUM_SLOTS)-1:0]     wr_addr,
   input  logic [$clog2(NUM_SLOTS+1)-1:0]   wr_data
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int LW = $clog2(NUM_SLOTS + 1);

   // slots at or above the fill count were never touched and still hold i+1
   logic [LW-1:0] fresh_ff, fresh_in;
   logic          virt_ff, virt_in;
   logic [LW-1:0] virt_val_ff, virt_val_in;
   logic [LW-1:0] ram_rd;
   logic [LW-1:0] addr_ext;

   assign addr_ext = LW'(rd_addr);

   always_comb begin
      fresh_in = fresh_ff;
      if (alloc_en && (addr_ext == fresh_ff)) begin
         fresh_in = fresh_ff + LW'(1);
      end
   end

   always_comb begin
      virt_in     = virt_ff;
      virt_val_in = virt_val_ff;
      if (rd_en) begin
         virt_in = (addr_ext >= fresh_ff);
         if (rd_addr == SW'(NUM_SLOTS - 1)) begin
            virt_val_in = LW'(NUM_SLOTS);
         end else begin
            virt_val_in = addr_ext + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= '0;
         virt_ff  <= 1'b0;
      end else begin
         fresh_ff <= fresh_in;
         virt_ff  <= virt_in;
      end
      virt_val_ff <= virt_val_in;
   end

   mqsb_ram #(
      .WIDTH (LW),
      .DEPTH (NUM_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign rd_data = virt_ff ? virt_val_ff : ram_rd;

endmodule

[rtl/core/multi_queue_shared_buffer_unit.sv]
// Several fifo queues sharing one store of NUM_SLOTS data slots, chained by a link memory
// with unused slots on a free list. A request transfer carries the operation and queue
// number in req_tuser and the push value in req_tdata; every request gives exactly one
// response transfer with the popped value (zero otherwise) and a status: ok, full (push
// with no free slot or a queue number at or above NUM_QUEUES) or empty (pop from an empty
// or nonexistent queue). A request passes ST_IDLE, then ST_EXEC: the first reads the link
// memory (and the data memory on a pop) while a push writes its datum and links the old
// tail, the second uses the registered link read to update the free list and, on a pop,
// the queue head, writes the final link and waits for a free output register. The single
// link write port forces the split: no request is taken until the last has left ST_EXEC.
// A finished response waits in the output register; the next request is taken while it is
// unclaimed. No clearing after reset: the link store's fill count tracks never-used slots.
module multi_queue_shared_buffer_unit
   import mqsb_pkg::*;
#(
   parameter int NUM_SLOTS  = 64,
   parameter int NUM_QUEUES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // push_data
   input  logic [QID_W:0]      req_tuser,   // req_type, queue_id
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // pop_data
   output logic [STATUS_W-1:0] rsp_tuser    // status
);

   localparam int SW  = $clog2(NUM_SLOTS);
   localparam int LW  = $clog2(NUM_SLOTS + 1);
   localparam int NQ  = (NUM_QUEUES < QID_SPAN) ? NUM_QUEUES : QID_SPAN;
   localparam int QIW = (NQ > 1) ? $clog2(NQ) : 1;
   localparam logic [LW-1:0] END_MARK = LW'(NUM_SLOTS);

   // request fields
   op_type              req_op;
   logic [QID_W-1:0]    req_qid;
   logic [QIW-1:0]      req_qi;

   // control state
   state_type           state_ff, state_in;
   logic [LW-1:0]       head_ff [NQ];
   logic [SW-1:0]       tail_ff [NQ];
   logic [LW-1:0]       free_head_ff, free_head_in;

   // request held from ST_IDLE into ST_EXEC
   op_type              op_ff;
   logic [QIW-1:0]      qi_ff;
   logic [SW-1:0]       slot_ff;
   logic                fail_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   status_type          rsp_status_ff, rsp_status_in;

   // handshake and decode
   logic                req_xfer;
   logic                exec_go;
   logic                q_ok;
   logic [LW-1:0]       head_q;
   logic                head_ok;
   logic                free_ok;
   logic                acc_fail;
   logic [SW-1:0]       acc_slot;

   // memory ports
   logic                link_rd_en;
   logic [LW-1:0]       link_rd;
   logic                link_wr_en;
   logic [SW-1:0]       link_wr_addr;
   logic [LW-1:0]       link_wr_data;
   logic                data_wr_en;
   logic                data_rd_en;
   logic [DATA_W-1:0]   data_rd;

   assign req_op  = op_type'(req_tuser[0]);
   assign req_qid = req_tuser[QID_W:1];
   assign req_qi  = QIW'(req_qid);

   assign req_xfer = req_tvalid && req_tready;
   // ST_EXEC only finishes once the response register is free
   assign exec_go  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign q_ok    = (int'(req_qid) < NUM_QUEUES);
   assign head_q  = q_ok ? head_ff[req_qi] : END_MARK;
   assign head_ok = (head_q != END_MARK);
   assign free_ok = (free_head_ff != END_MARK);

   always_comb begin
      if (req_op == OP_PUSH) begin
         acc_fail = !q_ok || !free_ok;
         acc_slot = free_head_ff[SW-1:0];
      end else begin
         acc_fail = !head_ok;
         acc_slot = head_q[SW-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine: memory commands
   always_comb begin
      req_tready   = 1'b0;
      link_rd_en   = 1'b0;
      link_wr_en   = 1'b0;
      link_wr_addr = '0;
      link_wr_data = '0;
      data_wr_en   = 1'b0;
      data_rd_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no transfer is taken while reset is held
            req_tready = !reset;
            if (req_xfer && !acc_fail) begin
               link_rd_en = 1'b1;
               if (req_op == OP_PUSH) begin
                  data_wr_en = 1'b1;
                  // link the old tail to the new slot
                  if (head_ok) begin
                     link_wr_en   = 1'b1;
                     link_wr_addr = tail_ff[req_qi];
                     link_wr_data = LW'(acc_slot);
                  end
               end else begin
                  data_rd_en = 1'b1;
               end
            end
         end
         ST_EXEC: begin
            if (exec_go && !fail_ff) begin
               link_wr_en   = 1'b1;
               link_wr_addr = slot_ff;
               // a pushed slot ends its queue, a popped slot heads the free list
               link_wr_data = (op_ff == OP_PUSH) ? END_MARK : free_head_ff;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      free_head_in = free_head_ff;
      if (exec_go && !fail_ff) begin
         free_head_in = (op_ff == OP_PUSH) ? link_rd : LW'(slot_ff);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         if (fail_ff) begin
            rsp_data_in   = '0;
            rsp_status_in = (op_ff == OP_PUSH) ? STATUS_FULL : STATUS_EMPTY;
         end else begin
            rsp_data_in   = (op_ff == OP_POP) ? data_rd : '0;
            rsp_status_in = STATUS_OK;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NQ; i++) begin
            head_ff[i] <= END_MARK;
         end
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer && !acc_fail) begin
            if (req_op == OP_PUSH) begin
               if (!head_ok) begin
                  head_ff[req_qi] <= LW'(acc_slot);
               end
            end
         end
         // pop: the next slot becomes the head (end marker empties the queue)
         if (exec_go && !fail_ff && (op_ff == OP_POP)) begin
            head_ff[qi_ff] <= link_rd;
         end
      end
      if (req_xfer && !acc_fail && (req_op == OP_PUSH)) begin
         tail_ff[req_qi] <= acc_slot;
      end
      if (req_xfer) begin
         op_ff   <= req_op;
         qi_ff   <= req_qi;
         slot_ff <= acc_slot;
         fail_ff <= acc_fail;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   mqsb_link_store #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_link_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (link_rd_en),
      .alloc_en (link_rd_en && (req_op == OP_PUSH)),
      .rd_addr  (acc_slot),
      .rd_data  (link_rd),
      .wr_en    (link_wr_en),
      .wr_addr  (link_wr_addr),
      .wr_data  (link_wr_data)
   );

   mqsb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (acc_slot),
      .wr_data (req_tdata),
      .rd_en   (data_rd_en),
      .rd_addr (acc_slot),
      .rd_data (data_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // an accepted request always enters ST_EXEC before the next one is taken
   a_two_cycles: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_EXEC) && !req_tready)
      else $error("request not held for its second cycle");

   // an unclaimed response is never overwritten
   a_rsp_interlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && rsp_valid_ff && !rsp_tready |=> (state_ff == ST_EXEC))
      else $error("response register overwritten");

   // a refused request leaves the free list alone
   a_fail_no_free_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && fail_ff |=> $stable(free_head_ff))
      else $error("free list changed by refused request");

   // only a good pop returns data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |-> (rsp_data_ff == '0))
      else $error("data returned with error status");

endmodule

[tb/shared_queue_checker.sv]
`timescale 1ns / 1ps

module shared_queue_checker
   import mqsb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // push_data
   input  logic [QID_W:0]      req_tuser,   // req_type, queue_id
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [DATA_W-1:0]   rsp_tdata,   // pop_data
   input  logic [STATUS_W-1:0] rsp_tuser,   // status
   output int                  errors,
   output int                  pending
);

   localparam int SLOTS  = 64;
   localparam int QUEUES = 4;
   localparam logic [6:0] CHAIN_END = 7'(SLOTS);

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
   } queue_result;

   logic [6:0]        head_of[QUEUES];
   logic [6:0]        tail_of[QUEUES];
   logic [6:0]        next_slot[SLOTS];
   logic [6:0]        free_slot;
   logic [DATA_W-1:0] slot_value[SLOTS];
   queue_result       due_results[$];

   function automatic queue_result apply_queue_op(input op_type op,
                                                  input logic [QID_W-1:0] qid,
                                                  input logic [DATA_W-1:0] value);
      queue_result res;
      logic [6:0]  slot;
      logic [6:0]  nxt;
      res.data   = '0;
      res.status = STATUS_OK;
      if (op == OP_PUSH) begin
         if (int'(qid) >= QUEUES || free_slot >= CHAIN_END) begin
            res.status = STATUS_FULL;
         end else begin
            slot      = free_slot;
            nxt       = next_slot[slot[5:0]];
            free_slot = (nxt < CHAIN_END) ? nxt : CHAIN_END;
            if (head_of[qid] >= CHAIN_END) begin
               head_of[qid] = slot;
            end else if (tail_of[qid] < CHAIN_END) begin
               next_slot[tail_of[qid][5:0]] = slot;
            end
            next_slot[slot[5:0]]  = CHAIN_END;
            tail_of[qid]          = slot;
            slot_value[slot[5:0]] = value;
         end
      end else begin
         if (int'(qid) >= QUEUES || head_of[qid] >= CHAIN_END) begin
            res.status = STATUS_EMPTY;
         end else begin
            slot                 = head_of[qid];
            nxt                  = next_slot[slot[5:0]];
            head_of[qid]         = (nxt < CHAIN_END) ? nxt : CHAIN_END;
            next_slot[slot[5:0]] = free_slot;
            free_slot            = slot;
            res.data             = slot_value[slot[5:0]];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      queue_result want;
      int          taken;
      int          given;
      int          fails;
      taken = 0;
      given = 0;
      fails = 0;
      if (reset) begin
         for (int q = 0; q < QUEUES; q++) begin
            head_of[q] = CHAIN_END;
            tail_of[q] = '0;
         end
         for (int s = 0; s < SLOTS; s++) begin
            next_slot[s]  = 7'(s + 1);
            slot_value[s] = '0;
         end
         free_slot = '0;
         due_results.delete();
         pending <= 0;
         errors  <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            due_results.push_back(apply_queue_op(op_type'(req_tuser[0]),
                                                 req_tuser[QID_W:1], req_tdata));
            taken = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, got data %h status %0d",
                        $time, rsp_tdata, rsp_tuser);
               fails++;
            end else begin
               want  = due_results.pop_front();
               given = 1;
               if (rsp_tdata !== want.data) begin
                  $display("%0t: pop_data mismatch, expected %h, got %h",
                           $time, want.data, rsp_tdata);
                  fails++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_tuser);
                  fails++;
               end
            end
         end
         pending <= pending + taken - given;
         errors  <= errors + fails;
      end
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import mqsb_pkg::*;

   // overall watchdog, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;
   // receiver hold-off long enough to back up the output register and the pipeline
   localparam int LONG_HOLD   = 60;
   localparam int BLOCK_ITEMS = 90;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;   // push_data
   logic [QID_W:0]      req_tuser;   // req_type, queue_id
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DATA_W-1:0]   rsp_tdata;   // pop_data
   logic [STATUS_W-1:0] rsp_tuser;   // status

   int errors;
   int pending;
   int cycle_count;

   // tail_phase and hold_asks are shared with the receiver and updated nonblocking; burst_left is the sender's own
   logic tail_phase;
   int   hold_asks;
   int   burst_left;

   // push share in percent for each random block: mixed, fill to full, mixed at full,
   // drain to empty, mixed, fill again, final drain
   int fill_bias[7] = '{50, 95, 50, 5, 60, 92, 8};

   multi_queue_shared_buffer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   shared_queue_checker queue_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // offer one request and hold it until the transfer edge; valid stays high afterwards
   task automatic send_request(input op_type op, input logic [QID_W-1:0] qid,
                               input logic [DATA_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= {qid, op};
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop offering until every outstanding response has come back
   task automatic await_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_request(input int push_share);
      op_type op;
      op = ($urandom_range(0, 99) < push_share) ? OP_PUSH : OP_POP;
      // short gaps, none during a forced burst or in the tail of the run
      if (!tail_phase && burst_left == 0 && $urandom_range(0, 4) == 0)
         idle_sender($urandom_range(1, 3));
      send_request(op, QID_W'($urandom_range(0, QID_SPAN - 1)), $urandom());
      if (burst_left > 0)
         burst_left--;
   endtask

   // sender
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      tail_phase = 1'b0;
      hold_asks  = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // pops on every queue straight after reset, all empty
      for (int q = 0; q < QID_SPAN; q++)
         send_request(OP_POP, q[QID_W-1:0], $urandom());
      // extreme values spread over the queues, two each on queues 0 and 3 to exercise tail linking
      send_request(OP_PUSH, 2'd0, 32'h7fff_ffff);
      send_request(OP_PUSH, 2'd0, 32'h8000_0000);
      send_request(OP_PUSH, 2'd1, 32'h0000_0000);
      send_request(OP_PUSH, 2'd2, 32'hffff_ffff);
      send_request(OP_PUSH, 2'd3, 32'haaaa_aaaa);
      send_request(OP_PUSH, 2'd3, 32'h5555_5555);
      // drain in fifo order, each pop of the last item leaves a stale tail
      send_request(OP_POP, 2'd0, $urandom());
      send_request(OP_POP, 2'd0, $urandom());
      send_request(OP_POP, 2'd1, $urandom());
      send_request(OP_POP, 2'd2, $urandom());
      send_request(OP_POP, 2'd3, $urandom());
      send_request(OP_POP, 2'd3, $urandom());
      send_request(OP_POP, 2'd2, $urandom());
      // refill after emptying: the stale tail must be replaced, not followed
      send_request(OP_PUSH, 2'd1, 32'h0000_0001);
      send_request(OP_POP, 2'd1, $urandom());
      send_request(OP_PUSH, 2'd2, 32'h1234_5678);
      send_request(OP_PUSH, 2'd2, 32'h8765_4321);
      send_request(OP_POP, 2'd2, $urandom());
      await_drain();

      for (int b = 0; b < 7; b++) begin
         if (b == 2) begin
            // long receiver hold-off while requests keep coming back to back
            hold_asks  <= hold_asks + 1;
            burst_left  = 12;
         end
         if (b == 6)
            tail_phase <= 1'b1;
         if (b == 4 || b == 6)
            await_drain();
         for (int n = 0; n < BLOCK_ITEMS; n++)
            random_request(fill_bias[b]);
      end

      await_drain();
      // allow for a late stray response after the last expected one
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // receiver: short random stalls, one long hold-off on request, none in the tail
   initial begin
      int stall_left;
      int holds_served;
      stall_left   = 0;
      holds_served = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_asks) begin
            holds_served = hold_asks;
            stall_left   = LONG_HOLD;
         end else if (!tail_phase && stall_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

endmodule

[multi_queue_shared_buffer_unit.f]
rtl/core/mqsb_pkg.sv
rtl/core/mqsb_ram.sv
rtl/core/mqsb_link_store.sv
rtl/core/multi_queue_shared_buffer_unit.sv
tb/shared_queue_checker.sv
tb/tb_top.sv
